// File: rtl/core/stm_pkg.sv
// shared types, constants and the quarter-wave sine and cosine tables
`timescale 1ns / 1ps
package stm_pkg;

   // field widths
   localparam int FREQ_BITS   = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 32;
   localparam int MAG_BITS    = 32;
   localparam int COEF_BITS   = 16;
   localparam int PROD_BITS   = 32;
   localparam int SUM_BITS    = 48;

   // lookup table geometry (power of two, quarter-wave folded)
   localparam int SINE_TABLE_SIZE = 1024;
   localparam int TABLE_BITS      = $clog2(SINE_TABLE_SIZE);
   localparam int QUARTER_SIZE    = SINE_TABLE_SIZE / 4;
   localparam int QUARTER_BITS    = TABLE_BITS - 2;

   // phase reduction: modulus = 2^PHASE_LOW_BITS * ODD_MODULUS
   localparam int PHASE_MODULUS   = 96000;
   localparam int PHASE_LOW_BITS  = 8;
   localparam int ODD_MODULUS     = PHASE_MODULUS >> PHASE_LOW_BITS;
   localparam int PRODUCT_BITS    = FREQ_BITS + INDEX_BITS;
   localparam int FOLD_SPLIT      = 28;
   localparam int FOLD_PART_BITS  = PRODUCT_BITS - FOLD_SPLIT;
   localparam int FOLD_FACTOR     = (1 << FOLD_PART_BITS) % ODD_MODULUS;
   localparam int FOLD_BITS       = 27;
   localparam int RECIP_SHIFT     = 35;
   localparam longint unsigned ODD_RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + ODD_MODULUS - 1) / ODD_MODULUS;
   localparam logic [FOLD_BITS-1:0] ODD_RECIP = FOLD_BITS'(ODD_RECIP_FULL);
   localparam int QUO_BITS        = 19;
   localparam int REM_BITS        = 9;
   localparam int ENTRY_SHIFT     = TABLE_BITS - PHASE_LOW_BITS;
   localparam int SCALED_BITS     = REM_BITS + PHASE_LOW_BITS + ENTRY_SHIFT;
   localparam int ENTRY_RSHIFT    = 27;
   localparam longint unsigned ENTRY_RECIP_FULL =
      ((64'd1 << ENTRY_RSHIFT) + ODD_MODULUS - 1) / ODD_MODULUS;
   localparam logic [SCALED_BITS-1:0] ENTRY_RECIP = SCALED_BITS'(ENTRY_RECIP_FULL);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // fixed-point constants for the table build
   localparam int Q30_SHIFT = 30;
   localparam int Q15_MAX   = 32767;
   localparam longint unsigned Q30_ONE     = 64'd1 << Q30_SHIFT;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [COEF_BITS-1:0] quarter_tab_type [QUARTER_SIZE];

   // finished segment sums handed from front to back
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sine_sum;
      logic signed [SUM_BITS-1:0] cosine_sum;
      logic                       first_segment;
   } seg_type;

   // q30 to q1.15 with rounding and clamp, odd symmetric
   function automatic logic signed [COEF_BITS-1:0] to_q15(input longint v);
      longint unsigned m;
      longint unsigned q;
      m = (v < 0) ? -v : v;
      q = (m * 64'd32767 + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
      if (q > 64'(Q15_MAX)) begin
         q = 64'(Q15_MAX);
      end
      return (v < 0) ? -$signed(COEF_BITS'(q)) : $signed(COEF_BITS'(q));
   endfunction

   // truncated taylor series for sine, terms to the 17th power
   function automatic longint series_sin(input longint unsigned a);
      longint unsigned a2;
      longint unsigned t;
      longint s;
      a2 = (a * a) >> Q30_SHIFT;
      t  = a;
      s  = longint'(a);
      t = ((t * a2) >> Q30_SHIFT) / 6;   s = s - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 20;  s = s + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 42;  s = s - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 72;  s = s + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 110; s = s - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 156; s = s + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 210; s = s - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 272; s = s + longint'(t);
      return s;
   endfunction

   // truncated taylor series for cosine, terms to the 16th power
   function automatic longint series_cos(input longint unsigned a);
      longint unsigned a2;
      longint unsigned t;
      longint c;
      a2 = (a * a) >> Q30_SHIFT;
      t  = Q30_ONE;
      c  = longint'(Q30_ONE);
      t = ((t * a2) >> Q30_SHIFT) / 2;   c = c - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 12;  c = c + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 30;  c = c - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 56;  c = c + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 90;  c = c - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 132; c = c + longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 182; c = c - longint'(t);
      t = ((t * a2) >> Q30_SHIFT) / 240; c = c + longint'(t);
      return c;
   endfunction

   // angle of quarter entry m in q30 radians
   function automatic longint unsigned quarter_angle(input int m);
      longint unsigned r;
      r = 64'(m) << (32 - TABLE_BITS);
      return (r * HALF_PI_Q30) >> Q30_SHIFT;
   endfunction

   function automatic quarter_tab_type build_sin_quarter();
      quarter_tab_type tab;
      for (int m = 0; m < QUARTER_SIZE; m++) begin
         tab[m] = to_q15(series_sin(quarter_angle(m)));
      end
      return tab;
   endfunction

   function automatic quarter_tab_type build_cos_quarter();
      quarter_tab_type tab;
      for (int m = 0; m < QUARTER_SIZE; m++) begin
         tab[m] = to_q15(series_cos(quarter_angle(m)));
      end
      return tab;
   endfunction

   localparam quarter_tab_type SIN_QUARTER = build_sin_quarter();
   localparam quarter_tab_type COS_QUARTER = build_cos_quarter();

endpackage

// File: rtl/core/segmented_tone_magnitude.sv
// top level: configuration register, front end, segment queue and back end
`timescale 1ns / 1ps
// Measures one tone over segments of a sample stream. Samples enter at up to one word per
// cycle while req_full is low: the front end reduces frequency times index modulo 96000 in a
// seven stage pipeline, looks up sine and cosine and accumulates both products. A segment end
// hands the two sums to a four entry queue. For each segment the back end takes the sums
// from the queue, forms partial products on one shared 24 by 24 multiplier, loads the
// radicand, runs a bit-serial square root and finishes once the result register is free.
// Short segments arriving back to back can fill the queue; req_full then rises and the
// whole front pipeline holds. The result waits in its own register, so the back end works
// on the next segment while a word is still unread. tone_frequency is taken on csr_valid
// and should be written only while nothing is in flight.
module segmented_tone_magnitude (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [stm_pkg::FREQ_BITS-1:0]         csr_tone_frequency,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [stm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [stm_pkg::INDEX_BITS-1:0]        req_sample_index,
   input  logic                                  req_segment_end,
   input  logic                                  req_buffer_start,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [stm_pkg::MAG_BITS-1:0]          rsp_magnitude
);
   import stm_pkg::*;

   logic [FREQ_BITS-1:0] tone_frequency_ff, tone_frequency_in;
   logic                 take;
   logic                 q_push, q_full, q_pop, q_empty;
   seg_type              q_push_word, q_head_word;

   // configuration register, always ready
   assign csr_ready = 1'b1;
   always_comb begin
      tone_frequency_in = (csr_valid && csr_ready) ? csr_tone_frequency : tone_frequency_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_frequency_ff <= '0;
      end else begin
         tone_frequency_ff <= tone_frequency_in;
      end
   end

   // input side stalls only on a full queue
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   stm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .tone_frequency (tone_frequency_ff),
      .take           (take),
      .sample         (req_sample),
      .sample_index   (req_sample_index),
      .segment_end    (req_segment_end),
      .buffer_start   (req_buffer_start),
      .queue_full     (q_full),
      .seg_push       (q_push),
      .seg_word       (q_push_word)
   );

   stm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_word (q_head_word),
      .empty     (q_empty)
   );

   stm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_word     (q_head_word),
      .queue_empty   (q_empty),
      .queue_pop     (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_magnitude (rsp_magnitude)
   );

   // the front never hands on a segment that the queue cannot hold
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("segment sums pushed into a full queue");

   // the back end only takes sums that are there
   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("segment queue popped while empty");

   // a taken input word is never lost to a stalled pipeline
   a_take_moves: assert property (@(posedge clock) disable iff (reset)
      take |-> !q_full && !req_full)
      else $error("input word taken while the pipeline holds");

endmodule

// File: rtl/core/stm_front.sv
// front end: phase reduction pipeline, table lookup and saturating accumulation
`timescale 1ns / 1ps
module stm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [stm_pkg::FREQ_BITS-1:0]   tone_frequency,
   input  logic                            take,
   input  logic signed [stm_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [stm_pkg::INDEX_BITS-1:0]  sample_index,
   input  logic                            segment_end,
   input  logic                            buffer_start,
   input  logic                            queue_full,
   output logic                            seg_push,
   output stm_pkg::seg_type                seg_word
);
   import stm_pkg::*;

   localparam int PIPE_STAGES = 7;
   localparam int LAST        = PIPE_STAGES - 1;
   localparam int RECIP_PROD_BITS = 2 * FOLD_BITS;
   localparam int ENTRY_PROD_BITS = 2 * SCALED_BITS;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          segment_end;
      logic                          buffer_start;
   } tag_type;

   // add a product to a sum, clamped to the signed sum range
   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]  acc,
      input logic signed [PROD_BITS-1:0] p
   );
      logic signed [SUM_BITS:0] wide;
      wide = {acc[SUM_BITS-1], acc} + {{(SUM_BITS+1-PROD_BITS){p[PROD_BITS-1]}}, p};
      if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
         return wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end
      return wide[SUM_BITS-1:0];
   endfunction

   logic                          advance;
   logic [PIPE_STAGES-1:0]        valid_ff;
   tag_type                       tag_ff [PIPE_STAGES];
   tag_type                       tag_in;

   logic [PRODUCT_BITS-1:0]       prod_ff,   prod_in;
   logic [FOLD_BITS-1:0]          fold_ff,   fold_in;
   logic [PHASE_LOW_BITS-1:0]     low_ff,    low_in;
   logic [FOLD_BITS-1:0]          fold3_ff,  fold3_in;
   logic [PHASE_LOW_BITS-1:0]     low3_ff,   low3_in;
   logic [QUO_BITS-1:0]           quo_ff,    quo_in;
   logic [SCALED_BITS-1:0]        scaled_ff, scaled_in;
   logic [TABLE_BITS-1:0]         entry_ff,  entry_in;
   logic signed [COEF_BITS-1:0]   sin_ff,    sin_in;
   logic signed [COEF_BITS-1:0]   cos_ff,    cos_in;
   logic signed [PROD_BITS-1:0]   psin_ff,   psin_in;
   logic signed [PROD_BITS-1:0]   pcos_ff,   pcos_in;
   logic signed [SUM_BITS-1:0]    sine_sum_ff,   sine_sum_in;
   logic signed [SUM_BITS-1:0]    cosine_sum_ff, cosine_sum_in;
   logic                          first_ff,  first_in;

   logic [RECIP_PROD_BITS-1:0]    recip_prod;
   logic [FOLD_BITS-1:0]          quo_mul;
   logic [FOLD_BITS-1:0]          rem_wide;
   logic [ENTRY_PROD_BITS-1:0]    entry_prod;
   logic signed [COEF_BITS-1:0]   qs, qc;
   logic signed [PROD_BITS-1:0]   smp_ext, sin_ext, cos_ext;
   tag_type                       cur_tag;
   logic signed [SUM_BITS-1:0]    base_s, base_c, new_s, new_c;
   logic                          first_cur;
   logic                          fire;

   // whole pipeline holds while the queue has no room
   assign advance = !queue_full;

   // phase product, modulus folding and table index
   always_comb begin
      tag_in    = '{sample: sample, segment_end: segment_end, buffer_start: buffer_start};
      prod_in   = PRODUCT_BITS'(tone_frequency) * PRODUCT_BITS'(sample_index);

      fold_in   = FOLD_BITS'(prod_ff[PRODUCT_BITS-1:FOLD_SPLIT]) * FOLD_BITS'(FOLD_FACTOR)
                + FOLD_BITS'(prod_ff[FOLD_SPLIT-1:PHASE_LOW_BITS]);
      low_in    = prod_ff[PHASE_LOW_BITS-1:0];

      recip_prod = RECIP_PROD_BITS'(fold_ff) * RECIP_PROD_BITS'(ODD_RECIP);
      quo_in     = recip_prod[RECIP_SHIFT +: QUO_BITS];
      fold3_in   = fold_ff;
      low3_in    = low_ff;

      quo_mul    = FOLD_BITS'(quo_ff) * FOLD_BITS'(ODD_MODULUS);
      rem_wide   = fold3_ff - quo_mul;
      scaled_in  = {rem_wide[REM_BITS-1:0], low3_ff, {ENTRY_SHIFT{1'b0}}};

      entry_prod = ENTRY_PROD_BITS'(scaled_ff) * ENTRY_PROD_BITS'(ENTRY_RECIP);
      entry_in   = entry_prod[ENTRY_RSHIFT +: TABLE_BITS];
   end

   // quarter-wave lookup unfolded by quadrant
   always_comb begin
      qs = SIN_QUARTER[entry_ff[QUARTER_BITS-1:0]];
      qc = COS_QUARTER[entry_ff[QUARTER_BITS-1:0]];
      case (entry_ff[TABLE_BITS-1 -: 2])
         QUAD_FIRST:  begin sin_in = qs;  cos_in = qc;  end
         QUAD_SECOND: begin sin_in = qc;  cos_in = -qs; end
         QUAD_THIRD:  begin sin_in = -qs; cos_in = -qc; end
         QUAD_FOURTH: begin sin_in = -qc; cos_in = qs;  end
         default:     begin sin_in = qs;  cos_in = qc;  end
      endcase
   end

   // sample times coefficient
   always_comb begin
      smp_ext = {{(PROD_BITS-SAMPLE_BITS){tag_ff[5].sample[SAMPLE_BITS-1]}}, tag_ff[5].sample};
      sin_ext = {{(PROD_BITS-COEF_BITS){sin_ff[COEF_BITS-1]}}, sin_ff};
      cos_ext = {{(PROD_BITS-COEF_BITS){cos_ff[COEF_BITS-1]}}, cos_ff};
      psin_in = smp_ext * sin_ext;
      pcos_in = smp_ext * cos_ext;
   end

   // accumulate; a segment end hands the sums on and clears them
   always_comb begin
      cur_tag   = tag_ff[LAST];
      fire      = advance && valid_ff[LAST];
      base_s    = cur_tag.buffer_start ? '0 : sine_sum_ff;
      base_c    = cur_tag.buffer_start ? '0 : cosine_sum_ff;
      new_s     = sat_add(base_s, psin_ff);
      new_c     = sat_add(base_c, pcos_ff);
      first_cur = cur_tag.buffer_start | first_ff;

      seg_push  = fire && cur_tag.segment_end;
      seg_word  = '{sine_sum: new_s, cosine_sum: new_c, first_segment: first_cur};

      sine_sum_in   = sine_sum_ff;
      cosine_sum_in = cosine_sum_ff;
      first_in      = first_ff;
      if (fire) begin
         if (cur_tag.segment_end) begin
            sine_sum_in   = '0;
            cosine_sum_in = '0;
            first_in      = 1'b0;
         end else begin
            sine_sum_in   = new_s;
            cosine_sum_in = new_c;
            first_in      = first_cur;
         end
      end
   end

   // stage valid bits and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         sine_sum_ff   <= '0;
         cosine_sum_ff <= '0;
         first_ff      <= 1'b1;
      end else begin
         if (advance) begin
            valid_ff <= {valid_ff[PIPE_STAGES-2:0], take};
         end
         sine_sum_ff   <= sine_sum_in;
         cosine_sum_ff <= cosine_sum_in;
         first_ff      <= first_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < PIPE_STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         prod_ff   <= prod_in;
         fold_ff   <= fold_in;
         low_ff    <= low_in;
         fold3_ff  <= fold3_in;
         low3_ff   <= low3_in;
         quo_ff    <= quo_in;
         scaled_ff <= scaled_in;
         entry_ff  <= entry_in;
         sin_ff    <= sin_in;
         cos_ff    <= cos_in;
         psin_ff   <= psin_in;
         pcos_ff   <= pcos_in;
      end
   end

endmodule

// File: rtl/core/stm_queue.sv
// short queue of finished segment sums between front and back
`timescale 1ns / 1ps
module stm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  stm_pkg::seg_type push_word,
   output logic             full,
   input  logic             pop,
   output stm_pkg::seg_type head_word,
   output logic             empty
);
   import stm_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   seg_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff,  count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = COUNT_BITS'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = COUNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: rtl/core/stm_back.sv
// back end: sum of squares, bit-serial square root, smoothing and result register
`timescale 1ns / 1ps
module stm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  stm_pkg::seg_type               head_word,
   input  logic                           queue_empty,
   output logic                           queue_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [stm_pkg::MAG_BITS-1:0]   rsp_magnitude
);
   import stm_pkg::*;

   localparam int HALF_BITS  = SUM_BITS / 2;
   localparam int PP_BITS    = 2 * HALF_BITS;
   localparam int ACC_BITS   = 2 * SUM_BITS;
   localparam int RAD_BITS   = 2 * MAG_BITS;
   localparam int REM_KEEP   = MAG_BITS + 1;
   localparam int TRY_BITS   = REM_KEEP + 2;
   localparam int COUNT_BITS = $clog2(MAG_BITS);

   // partial product steps of the two squares
   localparam logic [2:0] SQ_S_LOW   = 3'd0;
   localparam logic [2:0] SQ_S_CROSS = 3'd1;
   localparam logic [2:0] SQ_S_HIGH  = 3'd2;
   localparam logic [2:0] SQ_C_LOW   = 3'd3;
   localparam logic [2:0] SQ_C_CROSS = 3'd4;
   localparam logic [2:0] SQ_C_HIGH  = 3'd5;
   localparam logic [2:0] SQ_STEPS   = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_FINISH = 5'b10000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [SUM_BITS-1:0]     abs_s_ff, abs_s_in;
   logic [SUM_BITS-1:0]     abs_c_ff, abs_c_in;
   logic                    first_ff, first_in;
   logic [PP_BITS-1:0]      pp_ff, pp_in;
   logic [2:0]              pp_step_ff, pp_step_in;
   logic                    pp_live_ff, pp_live_in;
   logic [ACC_BITS-1:0]     acc_ff, acc_in;
   logic [RAD_BITS-1:0]     rad_ff, rad_in;
   logic [REM_KEEP-1:0]     rem_ff, rem_in;
   logic [MAG_BITS-1:0]     root_ff, root_in;
   logic                    sat_ff, sat_in;
   logic [MAG_BITS-1:0]     prev_ff, prev_in;
   logic                    out_valid_ff, out_valid_in;
   logic [MAG_BITS-1:0]     out_mag_ff, out_mag_in;

   logic [HALF_BITS-1:0]    op_a, op_b;
   logic [ACC_BITS-1:0]     addend;
   logic [TRY_BITS-1:0]     rem_shift, trial, rem_diff;
   logic [MAG_BITS-1:0]     raw_mag, mag;
   logic [MAG_BITS:0]       avg_sum;
   logic                    slot_free;

   assign rsp_empty     = !out_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign slot_free     = !out_valid_ff || rsp_pop;

   // operand halves for the shared multiplier
   always_comb begin
      case (count_ff[2:0]) inside
         SQ_S_LOW:   begin op_a = abs_s_ff[HALF_BITS-1:0];        op_b = abs_s_ff[HALF_BITS-1:0];        end
         SQ_S_CROSS: begin op_a = abs_s_ff[HALF_BITS-1:0];        op_b = abs_s_ff[SUM_BITS-1:HALF_BITS]; end
         SQ_S_HIGH:  begin op_a = abs_s_ff[SUM_BITS-1:HALF_BITS]; op_b = abs_s_ff[SUM_BITS-1:HALF_BITS]; end
         SQ_C_LOW:   begin op_a = abs_c_ff[HALF_BITS-1:0];        op_b = abs_c_ff[HALF_BITS-1:0];        end
         SQ_C_CROSS: begin op_a = abs_c_ff[HALF_BITS-1:0];        op_b = abs_c_ff[SUM_BITS-1:HALF_BITS]; end
         SQ_C_HIGH:  begin op_a = abs_c_ff[SUM_BITS-1:HALF_BITS]; op_b = abs_c_ff[SUM_BITS-1:HALF_BITS]; end
         default:    begin op_a = '0;                             op_b = '0;                             end
      endcase
      pp_in = PP_BITS'(op_a) * PP_BITS'(op_b);
   end

   // weight of the registered partial product; cross terms count twice
   always_comb begin
      case (pp_step_ff) inside
         SQ_S_LOW, SQ_C_LOW:     addend = ACC_BITS'(pp_ff);
         SQ_S_CROSS, SQ_C_CROSS: addend = ACC_BITS'(pp_ff) << (HALF_BITS + 1);
         SQ_S_HIGH, SQ_C_HIGH:   addend = ACC_BITS'(pp_ff) << (2 * HALF_BITS);
         default:                addend = '0;
      endcase
   end

   // one root bit per step
   always_comb begin
      rem_shift = {rem_ff, rad_ff[RAD_BITS-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      rem_diff  = rem_shift - trial;
   end

   // final value with smoothing
   always_comb begin
      raw_mag = sat_ff ? '1 : root_ff;
      avg_sum = {1'b0, raw_mag} + {1'b0, prev_ff};
      mag     = first_ff ? raw_mag : avg_sum[MAG_BITS:1];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      abs_s_in     = abs_s_ff;
      abs_c_in     = abs_c_ff;
      first_in     = first_ff;
      pp_step_in   = pp_step_ff;
      pp_live_in   = pp_live_ff;
      acc_in       = pp_live_ff ? ACC_BITS'(acc_ff + addend) : acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      sat_in       = sat_ff;
      prev_in      = prev_ff;
      out_mag_in   = out_mag_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      queue_pop    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            pp_live_in = 1'b0;
            if (!queue_empty) begin
               queue_pop = 1'b1;
               abs_s_in  = head_word.sine_sum[SUM_BITS-1]
                         ? SUM_BITS'(-head_word.sine_sum) : head_word.sine_sum;
               abs_c_in  = head_word.cosine_sum[SUM_BITS-1]
                         ? SUM_BITS'(-head_word.cosine_sum) : head_word.cosine_sum;
               first_in  = head_word.first_segment;
               acc_in    = '0;
               count_in  = '0;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (count_ff[2:0] == SQ_STEPS) begin
               pp_live_in = 1'b0;
               state_in   = ST_LOAD;
            end else begin
               pp_live_in = 1'b1;
               pp_step_in = count_ff[2:0];
               count_in   = COUNT_BITS'(count_ff + 1'b1);
            end
         end
         ST_LOAD: begin
            rad_in   = acc_ff[Q30_SHIFT +: RAD_BITS];
            sat_in   = |acc_ff[ACC_BITS-1:Q30_SHIFT+RAD_BITS];
            rem_in   = '0;
            root_in  = '0;
            count_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = rad_ff << 2;
            if (!rem_diff[TRY_BITS-1]) begin
               rem_in  = rem_diff[REM_KEEP-1:0];
               root_in = {root_ff[MAG_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[REM_KEEP-1:0];
               root_in = {root_ff[MAG_BITS-2:0], 1'b0};
            end
            count_in = COUNT_BITS'(count_ff + 1'b1);
            if (count_ff == '1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               out_mag_in   = mag;
               prev_in      = mag;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pp_live_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pp_live_ff   <= pp_live_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      abs_s_ff   <= abs_s_in;
      abs_c_ff   <= abs_c_in;
      first_ff   <= first_in;
      pp_ff      <= pp_in;
      pp_step_ff <= pp_step_in;
      acc_ff     <= acc_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      sat_ff     <= sat_in;
      out_mag_ff <= out_mag_in;
   end

endmodule

// File: bench/testbench.sv
// self-checking bench for the segmented tone magnitude block, with its own magnitude predictor
`timescale 1ns / 1ps
module testbench;

   localparam int TABLE_SIZE    = 1024;
   localparam int TONE_MODULUS  = 96000;
   localparam int SETTLE_CYCLES = 100;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_WORDS  = 312;
   localparam longint SUM_HIGH  = (64'sd1 <<< 47) - 1;
   localparam longint SUM_LOW   = -(64'sd1 <<< 47);

   // one sample word as it enters the block
   typedef struct {
      logic signed [stm_pkg::SAMPLE_BITS-1:0] sample;
      logic [stm_pkg::INDEX_BITS-1:0]        index;
      bit                                    seg_end;
      bit                                    buf_start;
   } tone_word_type;

   logic                                  clock;
   logic                                  reset              = 1'b1;
   logic                                  csr_valid          = 1'b0;
   logic                                  csr_ready;
   logic [stm_pkg::FREQ_BITS-1:0]         csr_tone_frequency = '0;
   logic                                  req_push           = 1'b0;
   logic                                  req_full;
   logic signed [stm_pkg::SAMPLE_BITS-1:0] req_sample        = '0;
   logic [stm_pkg::INDEX_BITS-1:0]        req_sample_index   = '0;
   logic                                  req_segment_end    = 1'b0;
   logic                                  req_buffer_start   = 1'b0;
   logic                                  rsp_empty;
   logic                                  rsp_pop            = 1'b0;
   logic [stm_pkg::MAG_BITS-1:0]          rsp_magnitude;

   segmented_tone_magnitude DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_tone_frequency (csr_tone_frequency),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_sample_index   (req_sample_index),
      .req_segment_end    (req_segment_end),
      .req_buffer_start   (req_buffer_start),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_magnitude      (rsp_magnitude)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state and lookup tables
   int                            sine_q15   [TABLE_SIZE];
   int                            cosine_q15 [TABLE_SIZE];
   logic [stm_pkg::FREQ_BITS-1:0] tone_freq_setting = '0;
   longint                        sine_acc          = 0;
   longint                        cosine_acc        = 0;
   logic [stm_pkg::MAG_BITS-1:0]  last_magnitude    = '0;
   bit                            fresh_buffer      = 1'b1;

   tone_word_type                 pending_words [$];
   logic [stm_pkg::MAG_BITS-1:0]  expected_magnitudes [$];
   int                            send_idle_pct  = 0;
   int                            recv_stall_pct = 0;
   int                            words_in       = 0;
   int                            words_out      = 0;
   int                            mismatches     = 0;
   int                            settings_used  = 0;
   int                            quiet_cycles   = 0;

   // q30 value to rounded, clamped q1.15
   function automatic int q30_to_q15(input longint v);
      longint unsigned mag;
      longint unsigned q;
      mag = (v < 0) ? -v : v;
      q = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return (v < 0) ? -int'(q) : int'(q);
   endfunction

   function automatic longint clamp_sum48(input longint v);
      if (v > SUM_HIGH) begin
         return SUM_HIGH;
      end
      if (v < SUM_LOW) begin
         return SUM_LOW;
      end
      return v;
   endfunction

   // advance the tone sums by one word; emits a magnitude on a segment end
   task automatic advance_tone_sums(input tone_word_type w, output bit emits,
                                    output logic [stm_pkg::MAG_BITS-1:0] mag);
      longint unsigned phase;
      longint unsigned entry;
      longint unsigned abs_s;
      longint unsigned abs_c;
      logic [127:0]    energy;
      logic [63:0]     reduced;
      logic [31:0]     root;
      logic [31:0]     trial;
      logic [31:0]     raw;
      if (w.buf_start) begin
         sine_acc     = 0;
         cosine_acc   = 0;
         fresh_buffer = 1'b1;
      end
      phase = (64'(tone_freq_setting) * 64'(w.index)) % 64'(TONE_MODULUS);
      entry = (phase * 64'(TABLE_SIZE)) / 64'(TONE_MODULUS);
      if (entry >= 64'(TABLE_SIZE)) begin
         entry = 64'(TABLE_SIZE - 1);
      end
      sine_acc   = clamp_sum48(sine_acc + longint'(w.sample) * sine_q15[entry]);
      cosine_acc = clamp_sum48(cosine_acc + longint'(w.sample) * cosine_q15[entry]);
      emits = w.seg_end;
      mag   = '0;
      if (w.seg_end) begin
         abs_s   = (sine_acc < 0) ? -sine_acc : sine_acc;
         abs_c   = (cosine_acc < 0) ? -cosine_acc : cosine_acc;
         energy  = (128'(abs_s) * 128'(abs_s) + 128'(abs_c) * 128'(abs_c)) >> 30;
         reduced = energy[63:0];
         // floor square root, one bit at a time from the top
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= reduced) begin
               root = trial;
            end
         end
         raw = (energy[127:64] != 0) ? 32'hFFFF_FFFF : root;
         if (!fresh_buffer) begin
            raw = 32'((33'(raw) + 33'(last_magnitude)) >> 1);
         end
         mag            = raw;
         last_magnitude = raw;
         fresh_buffer   = 1'b0;
         sine_acc       = 0;
         cosine_acc     = 0;
      end
   endtask

   // sample driver, fed from pending_words
   always @(posedge clock) begin : drive_words
      bit                           emits;
      logic [stm_pkg::MAG_BITS-1:0] mag;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            advance_tone_sums(pending_words[0], emits, mag);
            if (emits) begin
               expected_magnitudes.push_back(mag);
            end
            pending_words.delete(0);
            words_in++;
         end
         // a refused word is held as it is
         if (!(req_push && req_full)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push         <= 1'b1;
               req_sample       <= pending_words[0].sample;
               req_sample_index <= pending_words[0].index;
               req_segment_end  <= pending_words[0].seg_end;
               req_buffer_start <= pending_words[0].buf_start;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_magnitudes.size() == 0) begin
               $display("%0t: unexpected magnitude word, expected none, got %0d",
                        $time, rsp_magnitude);
               mismatches++;
            end else begin
               if (rsp_magnitude !== expected_magnitudes[0]) begin
                  $display("%0t: magnitude mismatch, expected %0d, got %0d",
                           $time, expected_magnitudes[0], rsp_magnitude);
                  mismatches++;
               end
               expected_magnitudes.delete(0);
            end
            words_out++;
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_word(input logic signed [15:0] sample, input logic [31:0] index,
                           input bit seg_end, input bit buf_start);
      tone_word_type w;
      w.sample    = sample;
      w.index     = index;
      w.seg_end   = seg_end;
      w.buf_start = buf_start;
      pending_words.push_back(w);
   endtask

   function automatic logic signed [15:0] pick_sample();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) begin
         return 16'sh8000;
      end
      if (sel == 1) begin
         return 16'sh7FFF;
      end
      return 16'($urandom);
   endfunction

   // wait for the block to drain, then let the pipelines empty
   task automatic settle_block();
      @(posedge clock);
      while (pending_words.size() != 0 || req_push || expected_magnitudes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tone_frequency(input logic [stm_pkg::FREQ_BITS-1:0] freq);
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_tone_frequency <= freq;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid         <= 1'b0;
      tone_freq_setting  = freq;
      settings_used++;
   endtask

   // mostly well-formed buffers of short segments, some noise and broken buffers
   task automatic queue_random_traffic(input int count);
      int          made;
      int          nseg;
      int          len;
      bit          drop_tail;
      bit          seg_end;
      bit          buf_start;
      logic [31:0] idx;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 12) begin
            add_word(pick_sample(), $urandom, $urandom_range(1), $urandom_range(3) == 0);
            made++;
         end else begin
            idx       = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                                 : $urandom;
            nseg      = $urandom_range(1, 5);
            drop_tail = ($urandom_range(5) == 0);
            for (int s = 0; s < nseg; s++) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  buf_start = (s == 0 && i == 0 && $urandom_range(7) != 0) ||
                              ($urandom_range(99) == 0);
                  seg_end   = (i == len - 1) && !(drop_tail && s == nseg - 1);
                  add_word(pick_sample(), idx, seg_end, buf_start);
                  idx  = ($urandom_range(49) == 0) ? $urandom : idx + 32'd2;
                  made++;
               end
            end
         end
      end
   endtask

   initial begin : main_sequence
      longint unsigned turn;
      longint unsigned r;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned ts;
      longint unsigned tc;
      longint          s;
      longint          c;
      int              idle_set [4][2];

      // q1.15 sine and cosine tables from truncated q30 series
      for (int k = 0; k < TABLE_SIZE; k++) begin
         turn = (64'(k) << 32) / 64'(TABLE_SIZE);
         r    = turn & ((64'd1 << 30) - 1);
         a    = (r * 64'd1686629713) >> 30;
         a2   = (a * a) >> 30;
         ts   = a;
         tc   = 64'd1 << 30;
         s    = longint'(a);
         c    = longint'(tc);
         for (int n = 1; n <= 8; n++) begin
            ts = ((ts * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * a2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               s = s - longint'(ts);
               c = c - longint'(tc);
            end else begin
               s = s + longint'(ts);
               c = c + longint'(tc);
            end
         end
         case (turn[31:30])
            2'd0: begin
               sine_q15[k] = q30_to_q15(s);  cosine_q15[k] = q30_to_q15(c);
            end
            2'd1: begin
               sine_q15[k] = q30_to_q15(c);  cosine_q15[k] = q30_to_q15(-s);
            end
            2'd2: begin
               sine_q15[k] = q30_to_q15(-s); cosine_q15[k] = q30_to_q15(-c);
            end
            default: begin
               sine_q15[k] = q30_to_q15(-c); cosine_q15[k] = q30_to_q15(s);
            end
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset frequency of zero: one-sample buffer, smoothing, dropped segment
      add_word(16'sh8000, 32'd0, 1'b1, 1'b1);
      add_word(16'sh7FFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      add_word(16'sd12345, 32'd2, 1'b0, 1'b0);
      add_word(-16'sd1, 32'd4, 1'b0, 1'b0);
      add_word(16'sd0, 32'd6, 1'b1, 1'b0);
      add_word(16'sh8000, 32'd8, 1'b0, 1'b0);
      add_word(16'sh7FFF, 32'd10, 1'b0, 1'b1);
      add_word(16'sh8000, 32'd12, 1'b1, 1'b0);
      settle_block();

      // top of the nominal frequency range
      write_tone_frequency(16'd48000);
      add_word(16'sh7FFF, 32'd1, 1'b0, 1'b1);
      add_word(16'sh8000, 32'd3, 1'b0, 1'b0);
      add_word(16'sh7FFF, 32'd5, 1'b1, 1'b0);
      add_word(16'sd100, 32'hFFFF_FFFE, 1'b1, 1'b0);
      settle_block();

      // frequency beyond the nominal range
      write_tone_frequency(16'hFFFF);
      add_word(16'sh8000, 32'hFFFF_FFFF, 1'b0, 1'b1);
      add_word(16'sh7FFF, 32'h8000_0000, 1'b0, 1'b0);
      add_word(-16'sd12000, 32'h7FFF_FFFF, 1'b1, 1'b0);
      add_word(16'sd0, 32'd0, 1'b1, 1'b1);
      settle_block();

      // random traffic: no idling, sender idle, receiver stalling, both
      idle_set[0] = '{0, 0};
      idle_set[1] = '{53, 0};
      idle_set[2] = '{0, 53};
      idle_set[3] = '{28, 28};
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       write_tone_frequency(16'($urandom_range(48000)));
            1:       write_tone_frequency(16'd1);
            2:       write_tone_frequency(16'($urandom));
            default: write_tone_frequency(16'($urandom_range(47000, 48000)));
         endcase
         send_idle_pct  = idle_set[p][0];
         recv_stall_pct = idle_set[p][1];
         queue_random_traffic(RANDOM_WORDS);
         settle_block();
      end

      $display("covered %0d sample words and %0d magnitude words", words_in, words_out);
      $display("over %0d frequency settings and four idling patterns, %0d mismatches",
               settings_used, mismatches);
      if (mismatches == 0 && expected_magnitudes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
